>>> rtl/core/block_average_mosaic_unit_defines.svh
// Assertion macros shared by the block average mosaic RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef BLOCK_AVERAGE_MOSAIC_UNIT_DEFINES_SVH
`define BLOCK_AVERAGE_MOSAIC_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BAM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/bam_pkg.sv
// Shared constants, types and helpers of the block average mosaic unit.
// No dependencies; imported by every module of the block but bam_ram.
`timescale 1ns / 1ps
`default_nettype none

package bam_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_BLOCK  = 64;

	localparam int NCH    = 4;                         // red, green, blue, alpha
	localparam int CH_W   = 8;
	localparam int SUM_W  = 20;
	localparam int COL_W  = $clog2(MAX_WIDTH);         // column / store index
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int DIM_W  = $clog2(MAX_WIDTH + 1);     // frame size incl. max
	localparam int BLK_W  = $clog2(MAX_BLOCK + 1);     // tile size incl. max
	localparam int OFS_W  = $clog2(MAX_BLOCK);         // offset inside a tile
	localparam int CNT_W  = 2 * BLK_W;                 // pixels per tile
	localparam int STEP_W = $clog2(CH_W);

	localparam int IN_TDATA_W  = NCH * CH_W;
	localparam int OUT_BITS    = NCH * CH_W + COL_W + ROW_W + 2 * BLK_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] NUM_REGS          = 3'd5;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hff;

	typedef logic [NCH-1:0][CH_W-1:0]  bam_pix_t;
	typedef logic [NCH-1:0][SUM_W-1:0] bam_sums_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [BLK_W-1:0] tw;
		logic [BLK_W-1:0] th;
		logic             frame_end;
	} bam_meta_t;

	typedef struct packed {
		bam_meta_t meta;
		logic      first;   // opens the tile: sums restart
		logic      last;    // closes the tile: average goes out
	} bam_tile_t;

	typedef struct packed {
		logic busy;
		logic done;
	} bam_div_stat_t;

	// 0 acts as 1, anything above max acts as max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] max_v);
		logic [DIM_W-1:0] r;
		begin
			if (v == '0) begin
				r = DIM_W'(1);
			end else if (v > max_v) begin
				r = max_v;
			end else begin
				r = v;
			end
			return r;
		end
	endfunction

	function automatic logic [BLK_W-1:0] clamp_blk(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		begin
			if (v == '0) begin
				r = BLK_W'(1);
			end else if (v > BLK_W'(MAX_BLOCK)) begin
				r = BLK_W'(MAX_BLOCK);
			end else begin
				r = v;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/bam_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read during write of the same address returns the old data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> rtl/core/bam_raster.sv
// Raster position counters and tile geometry of the current pixel.
// Depends on bam_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bam_raster (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic                     restart,
	input  logic [bam_pkg::DIM_W-1:0] frame_w,
	input  logic [bam_pkg::DIM_W-1:0] frame_h,
	input  logic [bam_pkg::BLK_W-1:0] blk_w,
	input  logic [bam_pkg::BLK_W-1:0] blk_h,
	output bam_pkg::bam_tile_t       tile
);
	import bam_pkg::*;

	logic [COL_W-1:0] pix_col_q;
	logic [ROW_W-1:0] pix_line_q;
	logic [OFS_W-1:0] col_in_q;
	logic [OFS_W-1:0] line_in_q;

	logic [COL_W-1:0] ocol;
	logic [ROW_W-1:0] orow;
	logic [DIM_W-1:0] rem_w, rem_h;
	logic [BLK_W-1:0] tw, th;
	logic             line_wrap, frame_wrap, col_in_wrap, line_in_wrap;

	always_comb begin
		ocol  = pix_col_q - COL_W'(col_in_q);
		orow  = pix_line_q - ROW_W'(line_in_q);
		rem_w = frame_w - DIM_W'(ocol);
		rem_h = frame_h - DIM_W'(orow);
		tw    = (rem_w < DIM_W'(blk_w)) ? BLK_W'(rem_w) : blk_w;
		th    = (rem_h < DIM_W'(blk_h)) ? BLK_W'(rem_h) : blk_h;

		line_wrap    = (DIM_W'(pix_col_q) + DIM_W'(1)) >= frame_w;
		frame_wrap   = (DIM_W'(pix_line_q) + DIM_W'(1)) >= frame_h;
		col_in_wrap  = (BLK_W'(col_in_q) + BLK_W'(1)) >= blk_w;
		line_in_wrap = (BLK_W'(line_in_q) + BLK_W'(1)) >= blk_h;

		tile.meta.col       = ocol;
		tile.meta.row       = orow;
		tile.meta.tw        = tw;
		tile.meta.th        = th;
		tile.meta.frame_end = line_wrap && frame_wrap;
		tile.first          = (col_in_q == '0) && (line_in_q == '0);
		tile.last           = ((BLK_W'(col_in_q) + BLK_W'(1)) == tw) &&
		                      ((BLK_W'(line_in_q) + BLK_W'(1)) == th);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_col_q  <= '0;
			pix_line_q <= '0;
			col_in_q   <= '0;
			line_in_q  <= '0;
		end else if (restart) begin
			pix_col_q  <= '0;
			pix_line_q <= '0;
			col_in_q   <= '0;
			line_in_q  <= '0;
		end else if (advance) begin
			if (line_wrap) begin
				pix_col_q <= '0;
				col_in_q  <= '0;
				if (frame_wrap) begin
					pix_line_q <= '0;
					line_in_q  <= '0;
				end else begin
					pix_line_q <= pix_line_q + ROW_W'(1);
					line_in_q  <= line_in_wrap ? '0 : line_in_q + OFS_W'(1);
				end
			end else begin
				pix_col_q <= pix_col_q + COL_W'(1);
				col_in_q  <= col_in_wrap ? '0 : col_in_q + OFS_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/bam_divider.sv
// Bit-serial restoring divider: four channel sums over one pixel count.
// One quotient bit per cycle, all channels in parallel. Depends on bam_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "block_average_mosaic_unit_defines.svh"

module bam_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  bam_pkg::bam_sums_t          sums,
	input  logic [bam_pkg::CNT_W-1:0]   divisor,
	input  logic                        ack,
	output bam_pkg::bam_pix_t           quo,
	output bam_pkg::bam_div_stat_t      stat
);
	import bam_pkg::*;

	localparam int DSH_W = CNT_W + CH_W - 1;

	logic              running_q, done_q;
	logic [STEP_W-1:0] step_q;
	logic [DSH_W-1:0]  dsh_q;
	bam_sums_t         rem_q;
	bam_pix_t          quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			step_q    <= '0;
		end else if (start) begin
			running_q <= 1'b1;
			done_q    <= 1'b0;
			step_q    <= '0;
		end else if (running_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(CH_W - 1)) begin
				running_q <= 1'b0;
				done_q    <= 1'b1;
			end
		end else if (ack) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= sums;
			quo_q <= '0;
			dsh_q <= DSH_W'(divisor) << (CH_W - 1);
		end else if (running_q) begin
			for (int c = 0; c < NCH; c++) begin
				if ({{(DSH_W - SUM_W){1'b0}}, rem_q[c]} >= dsh_q) begin
					rem_q[c] <= rem_q[c] - SUM_W'(dsh_q);
					quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b1};
				end else begin
					quo_q[c] <= {quo_q[c][CH_W-2:0], 1'b0};
				end
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quo       = quo_q;
	assign stat.busy = running_q || done_q;
	assign stat.done = done_q;

	`BAM_ASSERT_IMP(a_start_idle, start, !(running_q || done_q), "divider started while busy")
	`BAM_ASSERT_NXT(a_finish, running_q && step_q == STEP_W'(CH_W - 1) && !start, done_q, "divider missed finish")
	`BAM_ASSERT_NXT(a_hold, done_q && !ack && !start, done_q && $stable(quo_q), "divider result lost")

endmodule

`default_nettype wire

>>> rtl/core/block_average_mosaic_unit.sv
// Top level of the block average mosaic unit: config registers, sum store
// read-modify-write and output register. Depends on bam_pkg, bam_ram,
// bam_raster and bam_divider.
//
// Channel  Dir  Handshake            Payload (lowest bit first)
// s_*      in   s_tvalid/s_tready    tdata: red, green, blue, alpha
// m_*      out  m_tvalid/m_tready    tdata: avg r/g/b/a, tile_col, tile_row,
//                                    tile_w, tile_h, pad; tlast: frame_end
// cfg_*    in   cfg_we               cfg_index selects register, cfg_data value
//
// One pixel per clock while pixels do not close a tile and the divider is
// idle. The per-tile sums live in one 1024 x 80 RAM (read at accept,
// written in the next cycle, with a one-deep bypass for back-to-back
// pixels of the same tile). A pixel that closes a tile holds s_tready low
// while the shared serial divider spends one cycle per quotient bit and
// until it hands off the result, longer if m_tready stalls the output
// register. Reset clears control only; the sum RAM needs no clearing pass
// since each tile's first pixel starts from zero sums, not the stored entry.
`timescale 1ns / 1ps
`default_nettype none
`include "block_average_mosaic_unit_defines.svh"

module block_average_mosaic_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// pixel in: red, green, blue, alpha
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [bam_pkg::IN_TDATA_W-1:0]      s_tdata,
	// tile out: avg_red, avg_green, avg_blue, avg_alpha, tile_col, tile_row,
	// tile_w, tile_h, zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [bam_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [bam_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bam_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bam_pkg::*;

	// config registers, raw as written
	logic [DIM_W-1:0] img_w_raw_q, img_h_raw_q;
	logic [BLK_W-1:0] blk_w_raw_q, blk_h_raw_q;
	logic             alpha_en_q;
	logic [DIM_W-1:0] frame_w, frame_h;
	logic [BLK_W-1:0] blk_w, blk_h;
	logic             restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_raw_q <= DIM_W'(MAX_WIDTH);
			img_h_raw_q <= DIM_W'(MAX_HEIGHT);
			blk_w_raw_q <= BLK_W'(8);
			blk_h_raw_q <= BLK_W'(8);
			alpha_en_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   img_w_raw_q <= cfg_data;
				REG_IMAGE_HEIGHT:  img_h_raw_q <= cfg_data;
				REG_BLOCK_WIDTH:   blk_w_raw_q <= cfg_data[BLK_W-1:0];
				REG_BLOCK_HEIGHT:  blk_h_raw_q <= cfg_data[BLK_W-1:0];
				REG_ALPHA_PRESENT: alpha_en_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign restart = cfg_we && (cfg_index < NUM_REGS);
	assign frame_w = clamp_dim(img_w_raw_q, DIM_W'(MAX_WIDTH));
	assign frame_h = clamp_dim(img_h_raw_q, DIM_W'(MAX_HEIGHT));
	assign blk_w   = clamp_blk(blk_w_raw_q);
	assign blk_h   = clamp_blk(blk_h_raw_q);

	// input side
	logic          accept;
	bam_tile_t     tile;
	bam_pix_t      pix_in;
	bam_div_stat_t div_stat;

	logic          valid_s1, fwd_s1;
	bam_tile_t     tile_s1;
	bam_pix_t      pix_s1;
	bam_sums_t     fwd_sum_s1;
	bam_sums_t     rd_sums, base, new_sum;
	logic          fwd_hit;

	// stall while a closing pixel starts the divider, or the divider works or holds its result
	assign s_tready = !div_stat.busy && !(valid_s1 && tile_s1.last);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		pix_in    = bam_pix_t'(s_tdata);
		pix_in[3] = alpha_en_q ? s_tdata[IN_TDATA_W-1 -: CH_W] : ALPHA_OPAQUE;
	end

	bam_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.restart (restart),
		.frame_w (frame_w),
		.frame_h (frame_h),
		.blk_w   (blk_w),
		.blk_h   (blk_h),
		.tile    (tile)
	);

	// store entry sits at the tile's leftmost column
	bam_ram #(
		.WIDTH (NCH * SUM_W),
		.DEPTH (MAX_WIDTH)
	) u_sum_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (tile_s1.meta.col),
		.wdata (new_sum),
		.raddr (tile.meta.col),
		.rdata (rd_sums)
	);

	// previous pixel writes the entry this one reads in the same edge
	assign fwd_hit = valid_s1 && (tile_s1.meta.col == tile.meta.col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			fwd_s1   <= accept && fwd_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tile_s1    <= tile;
			pix_s1     <= pix_in;
			fwd_sum_s1 <= new_sum;
		end
	end

	always_comb begin
		if (tile_s1.first) begin
			base = '0;
		end else if (fwd_s1) begin
			base = fwd_sum_s1;
		end else begin
			base = rd_sums;
		end
		for (int c = 0; c < NCH; c++) begin
			new_sum[c] = base[c] + SUM_W'(pix_s1[c]);
		end
	end

	// averaging
	logic             div_start, div_ack;
	logic [CNT_W-1:0] pix_cnt;
	bam_pix_t         quo;
	bam_meta_t        meta_q;

	assign div_start = valid_s1 && tile_s1.last;
	assign pix_cnt   = CNT_W'(tile_s1.meta.tw) * CNT_W'(tile_s1.meta.th);

	bam_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.sums    (new_sum),
		.divisor (pix_cnt),
		.ack     (div_ack),
		.quo     (quo),
		.stat    (div_stat)
	);

	always_ff @(posedge clk) begin
		if (div_start) begin
			meta_q <= tile_s1.meta;
		end
	end

	// output register
	logic      out_valid_q;
	bam_pix_t  avg_q;
	bam_meta_t out_meta_q;

	assign div_ack = div_stat.done && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (div_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ack) begin
			avg_q      <= quo;
			out_meta_q <= meta_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_meta_q.frame_end;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_meta_q.th, out_meta_q.tw,
	                   out_meta_q.row, out_meta_q.col, avg_q};

	`BAM_ASSERT_IMP(a_div_free, valid_s1 && tile_s1.last, !div_stat.busy, "tile closed while divider busy")
	`BAM_ASSERT_NXT(a_fwd_set, accept && fwd_hit, fwd_s1 && valid_s1, "same-entry bypass missed")
	`BAM_ASSERT_IMP(a_out_src, $rose(out_valid_q), $past(div_stat.done), "output loaded without result")

endmodule

`default_nettype wire

>>> sim/tb_block_average_mosaic_unit.sv
// Self-checking testbench for block_average_mosaic_unit: random RGBA raster
// frames go in, tile averages are predicted in the bench and compared.
// Depends on bam_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_block_average_mosaic_unit;
	import bam_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 7;
	localparam int DRAIN_CYCLES    = 32;       // divider + RAM write-back, with margin
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_PIXELS   = 950;
	localparam int CALM_PIXELS     = 150;      // tail of the random part, no idling
	localparam int HOLD_OFF_CYCLES = 200;

	// tdata of one tile result, lowest field last
	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [BLK_W-1:0]     th;
		logic [BLK_W-1:0]     tw;
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
		bam_pix_t             avg;     // [0] red .. [3] alpha
	} tile_word_t;

	typedef struct {
		tile_word_t word;
		logic       frame_end;
	} tile_expect_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	bam_pix_t               s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	always #HALF_PERIOD clk = ~clk;

	block_average_mosaic_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// bench copy of the configuration, at reset values
	logic [DIM_W-1:0] reg_image_w  = 11'd1024;
	logic [DIM_W-1:0] reg_image_h  = 11'd1024;
	logic [BLK_W-1:0] reg_blk_w    = 7'd8;
	logic [BLK_W-1:0] reg_blk_h    = 7'd8;
	logic             reg_alpha_on = 1'b1;

	// bench copy of the raster position and the per-column tile sums
	int unsigned      pix_col      = 0;
	int unsigned      pix_line     = 0;
	int unsigned      col_in_tile  = 0;
	int unsigned      line_in_tile = 0;
	logic [SUM_W-1:0] tile_sums [MAX_WIDTH][NCH];

	tile_expect_t pending_tiles [$];

	int unsigned tx_idle_pct     = 0;
	int unsigned rx_stall_pct    = 0;
	int unsigned rx_gap          = 0;
	int unsigned rx_hold_cycles  = 0;
	int unsigned mismatches      = 0;
	int unsigned cycle_count     = 0;

	string        channel_names [NCH] = '{"avg_red", "avg_green", "avg_blue", "avg_alpha"};
	tile_word_t   seen;
	tile_expect_t want;
	int           ch_i;

	function automatic int unsigned limit_size(input int unsigned v, input int unsigned hi);
		if (v == 0) begin
			return 1;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

	function automatic void restart_raster();
		pix_col      = 0;
		pix_line     = 0;
		col_in_tile  = 0;
		line_in_tile = 0;
	endfunction

	// one accepted pixel: add to its tile's sums, queue the average if it
	// closes the tile, then step the raster position
	function automatic void accumulate_pixel(input bam_pix_t px);
		int unsigned  w, h, bw, bh, ocol, orow, tw, th, cnt, idx;
		bam_pix_t     val;
		tile_expect_t t;
		w   = limit_size(reg_image_w, MAX_WIDTH);
		h   = limit_size(reg_image_h, MAX_HEIGHT);
		bw  = limit_size(reg_blk_w, MAX_BLOCK);
		bh  = limit_size(reg_blk_h, MAX_BLOCK);
		val = px;
		if (!reg_alpha_on) begin
			val[3] = ALPHA_OPAQUE;
		end
		if (pix_col >= w || pix_line >= h || col_in_tile > pix_col ||
				line_in_tile > pix_line || col_in_tile >= bw || line_in_tile >= bh) begin
			restart_raster();
		end
		ocol = pix_col - col_in_tile;
		orow = pix_line - line_in_tile;
		tw   = (w - ocol < bw) ? w - ocol : bw;
		th   = (h - orow < bh) ? h - orow : bh;
		idx  = ocol % MAX_WIDTH;
		for (int c = 0; c < NCH; c++) begin
			if (col_in_tile == 0 && line_in_tile == 0) begin
				tile_sums[idx][c] = SUM_W'(val[c]);
			end else begin
				tile_sums[idx][c] = tile_sums[idx][c] + SUM_W'(val[c]);
			end
		end
		if (col_in_tile + 1 == tw && line_in_tile + 1 == th) begin
			cnt = tw * th;
			for (int c = 0; c < NCH; c++) begin
				t.word.avg[c] = CH_W'(tile_sums[idx][c] / cnt);
			end
			t.word.col   = COL_W'(ocol);
			t.word.row   = ROW_W'(orow);
			t.word.tw    = BLK_W'(tw);
			t.word.th    = BLK_W'(th);
			t.word.pad   = '0;
			t.frame_end  = (pix_col + 1 == w) && (pix_line + 1 == h);
			pending_tiles.push_back(t);
		end
		if (pix_col + 1 >= w) begin
			pix_col     = 0;
			col_in_tile = 0;
			if (pix_line + 1 >= h) begin
				pix_line     = 0;
				line_in_tile = 0;
			end else begin
				pix_line++;
				line_in_tile = (line_in_tile + 1 >= bh) ? 0 : line_in_tile + 1;
			end
		end else begin
			pix_col++;
			col_in_tile = (col_in_tile + 1 >= bw) ? 0 : col_in_tile + 1;
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// result checker: every accepted tile item against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen = tile_word_t'(m_tdata);
			if (pending_tiles.size() == 0) begin
				$display("%0t: unexpected tile item: expected none, actual tdata %h tlast %b",
					$time, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_tiles.pop_front();
				for (ch_i = 0; ch_i < NCH; ch_i++) begin
					check_field(channel_names[ch_i], want.word.avg[ch_i], seen.avg[ch_i]);
				end
				check_field("tile_col", want.word.col, seen.col);
				check_field("tile_row", want.word.row, seen.row);
				check_field("tile_w", want.word.tw, seen.tw);
				check_field("tile_h", want.word.th, seen.th);
				check_field("pad", want.word.pad, seen.pad);
				check_field("frame_end", want.frame_end, m_tlast);
			end
		end
	end

	// receiver: long hold-off on request, else random stall bursts
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			m_tready = 1'b0;
			rx_hold_cycles--;
		end else if (rx_gap > 0) begin
			m_tready = 1'b0;
			rx_gap--;
		end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
			m_tready = 1'b0;
			rx_gap   = $urandom_range(0, 13);
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic tx_pause(input int unsigned n);
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tdata  = bam_pix_t'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_pixel(input bam_pix_t px);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = px;
		do @(posedge clk); while (!s_tready);
		accumulate_pixel(px);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			tx_pause($urandom_range(1, 14));
		end
	endtask

	// wait until every predicted tile has come out and the pipe is quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_tiles.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:   reg_image_w  = value;
			REG_IMAGE_HEIGHT:  reg_image_h  = value;
			REG_BLOCK_WIDTH:   reg_blk_w    = value[BLK_W-1:0];
			REG_BLOCK_HEIGHT:  reg_blk_h    = value[BLK_W-1:0];
			REG_ALPHA_PRESENT: reg_alpha_on = value[0];
			default: ;
		endcase
		if (idx < NUM_REGS) begin
			restart_raster();
		end
	endtask

	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
		input logic [CFG_DATA_W-1:0] bw, input logic [CFG_DATA_W-1:0] bh);
		settle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_BLOCK_WIDTH, bw);
		write_reg(REG_BLOCK_HEIGHT, bh);
	endtask

	task automatic test_single_pixel_tiles();
		tx_idle_pct  = 20;
		rx_stall_pct = 10;
		set_frame(1, 1, 1, 1);
		send_pixel(32'h0000_0000);
		send_pixel(32'hffff_ffff);
		send_pixel(32'h55aa_55aa);
		send_pixel(32'haa55_aa55);
	endtask

	// alpha input ignored, taken as opaque; the register's upper data bits
	// must not matter
	task automatic test_alpha_absent();
		settle();
		write_reg(REG_ALPHA_PRESENT, 11'h7fe);
		send_pixel(32'h0012_3456);
		send_pixel(32'h80ff_00ff);
		settle();
		write_reg(REG_ALPHA_PRESENT, 11'h001);
	endtask

	// 5x3 frame in 2x2 tiles: right column and bottom row clipped
	task automatic test_clipped_tiles();
		set_frame(5, 3, 2, 2);
		repeat (15) send_pixel(bam_pix_t'($urandom));
	endtask

	// sizes of zero act as one, oversize acts as the maximum
	task automatic test_size_clamping();
		set_frame(0, 11'h7ff, 11'h47f, 0);
		repeat (3) send_pixel(bam_pix_t'($urandom));
	endtask

	// writes past the register list change nothing, not even the position
	task automatic test_unused_index();
		set_frame(4, 1, 4, 1);
		repeat (2) send_pixel(bam_pix_t'($urandom));
		settle();
		for (int k = NUM_REGS; k < 2 ** CFG_IDX_W; k++) begin
			write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
		end
		repeat (2) send_pixel(bam_pix_t'($urandom));
	endtask

	task automatic test_largest_tiles();
		set_frame(DIM_W'(MAX_BLOCK), 1, CFG_DATA_W'(MAX_BLOCK), 1);
		repeat (MAX_BLOCK) send_pixel(32'hffff_ffff);
		set_frame(1, DIM_W'(MAX_BLOCK), 1, CFG_DATA_W'(MAX_BLOCK));
		repeat (MAX_BLOCK) send_pixel(bam_pix_t'($urandom));
	endtask

	// one-pixel tiles with the output held off: the block must fill and
	// stall the pixel side; then the sender waits for a full drain and the
	// frame goes on without a config write
	task automatic test_output_backpressure();
		set_frame(4, 4, 1, 1);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		@(posedge clk);
		rx_hold_cycles = HOLD_OFF_CYCLES;
		repeat (16) send_pixel(bam_pix_t'($urandom));
		settle();
		repeat (16) send_pixel(bam_pix_t'($urandom));
	endtask

	task automatic test_random_frames();
		int unsigned      sent, n, area;
		logic [DIM_W-1:0] w, h;
		logic [BLK_W-1:0] bw, bh;
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0: begin
					// long lines, one-line tiles
					case ($urandom_range(0, 2))
						0: w = 11'd1024;
						1: w = DIM_W'($urandom_range(1025, 2047));
						default: w = DIM_W'($urandom_range(65, 1023));
					endcase
					h  = DIM_W'($urandom_range(1, 3));
					bw = BLK_W'($urandom_range(0, 127));
					bh = BLK_W'($urandom_range(0, 1));
					n  = $urandom_range(64, 200);
				end
				1: begin
					// narrow and tall
					w  = DIM_W'($urandom_range(1, 3));
					h  = DIM_W'($urandom_range(65, 2047));
					bw = BLK_W'($urandom_range(0, 3));
					bh = BLK_W'($urandom_range(0, 127));
					n  = $urandom_range(64, 200);
				end
				default: begin
					// small frames, whole frames plus sometimes a cut one
					w  = DIM_W'($urandom_range(0, 12));
					h  = DIM_W'($urandom_range(0, 10));
					bw = ($urandom_range(0, 9) == 0) ? BLK_W'($urandom_range(65, 127))
						: BLK_W'($urandom_range(0, 8));
					bh = ($urandom_range(0, 9) == 0) ? BLK_W'($urandom_range(65, 127))
						: BLK_W'($urandom_range(0, 8));
					area = limit_size(w, MAX_WIDTH) * limit_size(h, MAX_HEIGHT);
					n = area * $urandom_range(1, 3);
					if ($urandom_range(0, 1) == 1) begin
						n += $urandom_range(0, area - 1);
					end
				end
			endcase
			// keep the total near the planned pixel count
			if (n > RANDOM_PIXELS - sent) begin
				n = RANDOM_PIXELS - sent;
			end
			settle();
			write_reg(REG_IMAGE_WIDTH, w);
			write_reg(REG_IMAGE_HEIGHT, h);
			write_reg(REG_BLOCK_WIDTH, {4'($urandom), bw});
			write_reg(REG_BLOCK_HEIGHT, {4'($urandom), bh});
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_ALPHA_PRESENT, CFG_DATA_W'($urandom));
			end
			case ($urandom_range(0, 2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 15;
				default: tx_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 5;
				default: rx_stall_pct = 20;
			endcase
			repeat (n) begin
				if (sent >= RANDOM_PIXELS - CALM_PIXELS) begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				send_pixel(bam_pix_t'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_single_pixel_tiles();
		test_alpha_absent();
		test_clipped_tiles();
		test_size_clamping();
		test_unused_index();
		test_output_backpressure();
		test_largest_tiles();
		test_random_frames();
		settle();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/bam_pkg.sv
rtl/core/bam_ram.sv
rtl/core/bam_raster.sv
rtl/core/bam_divider.sv
rtl/core/block_average_mosaic_unit.sv
sim/tb_block_average_mosaic_unit.sv
